// File: sv/lif_neuron_with_psp_ring_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the leaky integrate-and-fire neuron array.
// Each macro expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LIF_NEURON_WITH_PSP_RING_ASSERT_SVH
`define LIF_NEURON_WITH_PSP_RING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LNR_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LNR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: sv/lnr_pkg.sv
// ---------------------------------------------------------------------------
// lnr_pkg
// Shared constants, codes and types of the neuron array.
// ---------------------------------------------------------------------------
`default_nettype none

package lnr_pkg;

	localparam int NEURONS      = 256;
	localparam int RING_SLOTS   = 32;
	localparam int WEIGHT_SHIFT = 8;
	localparam int SCALE_SHIFT  = 16;

	localparam int NEURON_W   = $clog2(NEURONS);
	localparam int SLOT_W     = $clog2(RING_SLOTS);
	localparam int RING_AW    = NEURON_W + SLOT_W;
	localparam int RING_DEPTH = NEURONS * RING_SLOTS;
	localparam int CLR_W      = RING_AW + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [1:0] FUNC_SYN  = 2'd0;
	localparam logic [1:0] FUNC_UPD  = 2'd1;
	localparam logic [1:0] FUNC_BIAS = 2'd2;

	localparam logic [2:0] SYN_EXCITE  = 3'd0;
	localparam logic [2:0] SYN_INHIBIT = 3'd1;

	localparam logic [31:0] WEIGHT_MASK = 32'h0000_fff8;

	localparam logic [CFG_IDX_W-1:0] REG_REST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MDECAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESIST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EDECAY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IDECAY = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REFR   = 3'd7;

	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

// File: sv/lnr_if.sv
// ---------------------------------------------------------------------------
// lnr_cmd_if / lnr_res_if
// Valid/ready channels carrying command items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface lnr_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [31:0]        tick;
	logic [31:0]        syn_word;
	logic               row_last;
	logic [7:0]         neuron_sel;
	logic signed [31:0] bias_value;

	modport source (output valid, func, tick, syn_word, row_last, neuron_sel, bias_value,
		input ready);
	modport sink (input valid, func, tick, syn_word, row_last, neuron_sel, bias_value,
		output ready);
endinterface

interface lnr_res_if;
	logic               valid;
	logic               ready;
	logic               spiked;
	logic [7:0]         neuron_out;
	logic signed [31:0] membrane_v;
	logic               in_refractory;

	modport source (output valid, spiked, neuron_out, membrane_v, in_refractory,
		input ready);
	modport sink (input valid, spiked, neuron_out, membrane_v, in_refractory,
		output ready);
endinterface

`default_nettype wire

// File: sv/lif_neuron_with_psp_ring.sv
// ---------------------------------------------------------------------------
// lif_neuron_with_psp_ring
// Fixed-point leaky integrate-and-fire neuron array with delay rings.
// ---------------------------------------------------------------------------
// After reset a clearing pass zeroes all stores; no item is taken.
// Synapse, bias and idle items pass the read, decode and finish states.
// Updates use the one shared multiplier; refractory ones skip the membrane states.
// One item is worked at a time; the result register lets the next item in.
// Reset is asynchronous and active low; configuration returns to reset values.
`default_nettype none

module lif_neuron_with_psp_ring (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [lnr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lnr_pkg::CFG_DATA_W-1:0]     cfg_data,
	lnr_cmd_if.sink                                 cmd,
	lnr_res_if.source                               res
);

	localparam int NW  = lnr_pkg::NEURON_W;
	localparam int SW  = lnr_pkg::SLOT_W;
	localparam int AW  = lnr_pkg::RING_AW;
	localparam int SS  = lnr_pkg::SCALE_SHIFT;
	localparam int PW  = lnr_pkg::MUL_P_W;
	localparam int AWM = lnr_pkg::MUL_A_W;
	localparam int BWM = lnr_pkg::MUL_B_W;
	localparam int INP_W = PW - SS + 1;
	localparam int XQ_W  = SS + 34;
	localparam int X_W   = ((INP_W > XQ_W) ? INP_W : XQ_W) + 2;
	localparam int HP_W  = AWM + 17;
	localparam int DV_W  = HP_W + 2;
	localparam int VS_W  = DV_W + 1;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_DEC  = 4'd3;
	localparam logic [3:0] ST_MULC = 4'd4;
	localparam logic [3:0] ST_INP  = 4'd5;
	localparam logic [3:0] ST_X    = 4'd6;
	localparam logic [3:0] ST_MHI  = 4'd7;
	localparam logic [3:0] ST_MLO  = 4'd8;
	localparam logic [3:0] ST_DV   = 4'd9;
	localparam logic [3:0] ST_VUPD = 4'd10;
	localparam logic [3:0] ST_DECE = 4'd11;
	localparam logic [3:0] ST_DECI = 4'd12;
	localparam logic [3:0] ST_WRE  = 4'd13;
	localparam logic [3:0] ST_WRI  = 4'd14;
	localparam logic [3:0] ST_FIN  = 4'd15;

	localparam logic [PW-1:0] SMASK = PW'((64'd1 << SS) - 64'd1);
	localparam logic signed [X_W-1:0] X_LIM = X_W'(64'd1 << (SS + 32));
	localparam logic signed [VS_W-1:0] V_MAX = VS_W'(64'sd2147483647);
	localparam logic signed [VS_W-1:0] V_MIN = -VS_W'(64'sd2147483648);

	// Next current = cur - floor(cur * d / 2^SS), taken from |cur| * d.
	function automatic logic [31:0] decay_next(logic [31:0] cur, logic [PW-1:0] p);
		logic [PW-1:0] fl;
		logic [PW-1:0] ce;
		begin
			fl = p >> SS;
			ce = (p + SMASK) >> SS;
			decay_next = cur[31] ? cur + ce[31:0] : cur - fl[31:0];
		end
	endfunction

	// Configuration registers.
	logic signed [31:0] rest_q, rstv_q, thr_q, resist_q;
	logic [16:0]        mdec_q, edec_q, idec_q;
	logic [15:0]        refr_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q       <= '0;
			rstv_q       <= '0;
			thr_q        <= 32'sh7fff_ffff;
			resist_q     <= '0;
			mdec_q       <= '0;
			edec_q       <= '0;
			idec_q       <= '0;
			refr_ticks_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lnr_pkg::REG_REST:   rest_q       <= cfg_data;
				lnr_pkg::REG_RESET:  rstv_q       <= cfg_data;
				lnr_pkg::REG_THRESH: thr_q        <= cfg_data;
				lnr_pkg::REG_MDECAY: mdec_q       <= cfg_data[16:0];
				lnr_pkg::REG_RESIST: resist_q     <= cfg_data;
				lnr_pkg::REG_EDECAY: edec_q       <= cfg_data[16:0];
				lnr_pkg::REG_IDECAY: idec_q       <= cfg_data[16:0];
				lnr_pkg::REG_REFR:   refr_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Control state.
	logic [3:0]                 state_q, state_d;
	logic [lnr_pkg::CLR_W-1:0]  clr_q;
	logic                       out_valid_q;
	logic                       accept, load_out;

	// Item and working registers.
	logic [1:0]          func_q;
	logic [31:0]         tick_q, word_q;
	logic [7:0]          sel_q;
	logic [31:0]         bias_in_q;
	logic [31:0]         cur_e_q, cur_i_q, v_q;
	logic signed [33:0]  c_q;
	logic                pneg_q, xneg_q;
	logic signed [INP_W-1:0] inp_q;
	logic signed [XQ_W-1:0]  x_q;
	logic [HP_W-1:0]     hiprod_q;
	logic signed [DV_W-1:0]  dv_q;
	logic [31:0]         ne_q, ni_q;
	logic                w_spk_q, w_refr_q;
	logic [31:0]         w_v_q;
	logic                o_spk_q, o_refr_q;
	logic [7:0]          o_idx_q;
	logic [31:0]         o_v_q;

	// Memories and their ports.
	logic [31:0] exc_mem [lnr_pkg::RING_DEPTH];
	logic [31:0] inh_mem [lnr_pkg::RING_DEPTH];
	logic [31:0] pot_mem [lnr_pkg::NEURONS];
	logic [15:0] rc_mem  [lnr_pkg::NEURONS];
	logic [31:0] bias_mem [lnr_pkg::NEURONS];
	logic [31:0] exc_rd_q, inh_rd_q, pot_rd_q, bias_rd_q;
	logic [15:0] rc_rd_q;

	logic          ex_we, ih_we, pot_we, rc_we, bias_we, ring_re, small_re;
	logic [AW-1:0] ex_wa, ih_wa, ring_ra;
	logic [NW-1:0] sm_wa;
	logic [31:0]   ex_wd, ih_wd, pot_wd, bias_wd;
	logic [15:0]   rc_wd;

	// Item decode.
	logic [10:0]   tgt;
	logic          tgt_ok, sel_ok, is_syn, in_range;
	logic [NW-1:0] idx;
	logic [31:0]   arrive, tick_p1, weight;
	logic [AW-1:0] addr_a, addr_n;

	assign tgt     = word_q[26:16];
	assign tgt_ok  = 12'(tgt) < 12'(lnr_pkg::NEURONS);
	assign sel_ok  = 12'(sel_q) < 12'(lnr_pkg::NEURONS);
	assign is_syn  = func_q == lnr_pkg::FUNC_SYN;
	assign in_range = is_syn ? tgt_ok : sel_ok;
	assign idx     = is_syn ? NW'(tgt) : NW'(sel_q);
	assign tick_p1 = tick_q + 32'd1;
	assign arrive  = tick_p1 + 32'(word_q[31:28]);
	assign weight  = 32'((word_q & lnr_pkg::WEIGHT_MASK) << lnr_pkg::WEIGHT_SHIFT);
	assign addr_a  = {idx, is_syn ? arrive[SW-1:0] : tick_q[SW-1:0]};
	assign addr_n  = {idx, tick_p1[SW-1:0]};

	// Shared multiplier.
	lnr_pkg::mul_req_t mreq;
	logic [PW-1:0]     prod;

	lnr_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// Arithmetic between the sequencer steps.
	logic [33:0]            c_neg;
	logic [31:0]            r_mag;
	logic [PW-1:0]          p_fl, p_ce, p_mag;
	logic signed [X_W-1:0]  xs;
	logic signed [XQ_W-1:0] x_sat;
	logic [XQ_W-1:0]        x_mag;
	logic [32:0]            e_mag, i_mag;
	logic [HP_W-1:0]        lo_fl, lo_ce;
	logic signed [VS_W-1:0] vs;
	logic signed [31:0]     v_sat, v_new;
	logic                   fire;

	always_comb begin
		c_neg = -c_q;
		r_mag = resist_q[31] ? 32'(-resist_q) : resist_q;
		p_fl  = prod >> SS;
		p_ce  = (prod + SMASK) >> SS;
		p_mag = pneg_q ? p_ce : p_fl;
		xs    = X_W'(rest_q) - X_W'($signed(v_q)) + X_W'(inp_q);
		if (xs > X_LIM) begin
			x_sat = XQ_W'(X_LIM);
		end else if (xs < -X_LIM) begin
			x_sat = XQ_W'(-X_LIM);
		end else begin
			x_sat = XQ_W'(xs);
		end
		x_mag = x_q[XQ_W-1] ? XQ_W'(-x_q) : XQ_W'(x_q);
		e_mag = cur_e_q[31] ? -{1'b1, cur_e_q} : {1'b0, cur_e_q};
		i_mag = cur_i_q[31] ? -{1'b1, cur_i_q} : {1'b0, cur_i_q};
		lo_fl = HP_W'(p_fl);
		lo_ce = HP_W'(p_ce);
		vs    = VS_W'($signed(v_q)) + VS_W'(dv_q);
		if (vs > V_MAX) begin
			v_sat = 32'h7fff_ffff;
		end else if (vs < V_MIN) begin
			v_sat = 32'h8000_0000;
		end else begin
			v_sat = 32'(vs);
		end
		fire  = v_sat >= thr_q;
		v_new = fire ? rstv_q : v_sat;
	end

	assign accept   = cmd.valid && cmd.ready;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || res.ready);

	// Sequencer, memory port control and multiplier requests.
	always_comb begin
		state_d  = state_q;
		ex_we    = 1'b0;
		ih_we    = 1'b0;
		pot_we   = 1'b0;
		rc_we    = 1'b0;
		bias_we  = 1'b0;
		ex_wa    = addr_a;
		ih_wa    = addr_a;
		sm_wa    = idx;
		ex_wd    = '0;
		ih_wd    = '0;
		pot_wd   = v_new;
		rc_wd    = '0;
		bias_wd  = bias_in_q;
		ring_re  = 1'b0;
		small_re = 1'b0;
		ring_ra  = addr_a;
		mreq     = '0;
		case (state_q)
			ST_CLR: begin
				ex_we   = 1'b1;
				ih_we   = 1'b1;
				pot_we  = 1'b1;
				rc_we   = 1'b1;
				bias_we = 1'b1;
				ex_wa   = clr_q[AW-1:0];
				ih_wa   = clr_q[AW-1:0];
				sm_wa   = clr_q[NW-1:0];
				pot_wd  = '0;
				bias_wd = '0;
				if (clr_q[AW]) begin
					ex_we   = 1'b0;
					ih_we   = 1'b0;
					pot_we  = 1'b0;
					rc_we   = 1'b0;
					bias_we = 1'b0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				ring_re  = 1'b1;
				small_re = 1'b1;
				state_d  = ST_DEC;
			end
			ST_DEC: begin
				state_d = ST_FIN;
				case (func_q)
					lnr_pkg::FUNC_SYN: begin
						if (tgt_ok && word_q[2:0] == lnr_pkg::SYN_EXCITE) begin
							ex_we = 1'b1;
							ex_wd = exc_rd_q + weight;
						end
						if (tgt_ok && word_q[2:0] == lnr_pkg::SYN_INHIBIT) begin
							ih_we = 1'b1;
							ih_wd = inh_rd_q + weight;
						end
					end
					lnr_pkg::FUNC_BIAS: begin
						bias_we = sel_ok;
					end
					lnr_pkg::FUNC_UPD: begin
						if (sel_ok) begin
							ex_we = 1'b1;
							ih_we = 1'b1;
							if (rc_rd_q != 16'd0) begin
								rc_we   = 1'b1;
								rc_wd   = rc_rd_q - 16'd1;
								state_d = ST_DECE;
							end else begin
								state_d = ST_MULC;
							end
						end
					end
					default: ;
				endcase
			end
			ST_MULC: begin
				mreq.en = 1'b1;
				mreq.a  = c_q[33] ? c_neg[AWM-1:0] : c_q[AWM-1:0];
				mreq.b  = BWM'(r_mag);
				state_d = ST_INP;
			end
			ST_INP: begin
				state_d = ST_X;
			end
			ST_X: begin
				state_d = ST_MHI;
			end
			ST_MHI: begin
				mreq.en = 1'b1;
				mreq.a  = AWM'(x_mag >> SS);
				mreq.b  = BWM'(mdec_q);
				state_d = ST_MLO;
			end
			ST_MLO: begin
				mreq.en = 1'b1;
				mreq.a  = AWM'(x_mag[SS-1:0]);
				mreq.b  = BWM'(mdec_q);
				state_d = ST_DV;
			end
			ST_DV: begin
				state_d = ST_VUPD;
			end
			ST_VUPD: begin
				pot_we  = 1'b1;
				rc_we   = fire;
				rc_wd   = refr_ticks_q;
				state_d = ST_DECE;
			end
			ST_DECE: begin
				mreq.en = 1'b1;
				mreq.a  = AWM'(e_mag);
				mreq.b  = BWM'(edec_q);
				ring_re = 1'b1;
				ring_ra = addr_n;
				state_d = ST_DECI;
			end
			ST_DECI: begin
				mreq.en = 1'b1;
				mreq.a  = AWM'(i_mag);
				mreq.b  = BWM'(idec_q);
				state_d = ST_WRE;
			end
			ST_WRE: begin
				ex_we   = 1'b1;
				ex_wa   = addr_n;
				ex_wd   = exc_rd_q + ne_q;
				state_d = ST_WRI;
			end
			ST_WRI: begin
				ih_we   = 1'b1;
				ih_wa   = addr_n;
				ih_wd   = inh_rd_q + ni_q;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ex_we) begin
			exc_mem[ex_wa] <= ex_wd;
		end
		if (ring_re) begin
			exc_rd_q <= exc_mem[ring_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (ih_we) begin
			inh_mem[ih_wa] <= ih_wd;
		end
		if (ring_re) begin
			inh_rd_q <= inh_mem[ring_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pot_we) begin
			pot_mem[sm_wa] <= pot_wd;
		end
		if (small_re) begin
			pot_rd_q <= pot_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (rc_we) begin
			rc_mem[sm_wa] <= rc_wd;
		end
		if (small_re) begin
			rc_rd_q <= rc_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (bias_we) begin
			bias_mem[sm_wa] <= bias_wd;
		end
		if (small_re) begin
			bias_rd_q <= bias_mem[idx];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= cmd.func;
			tick_q    <= cmd.tick;
			word_q    <= cmd.syn_word;
			sel_q     <= cmd.neuron_sel;
			bias_in_q <= cmd.bias_value;
		end
		case (state_q)
			ST_DEC: begin
				cur_e_q  <= exc_rd_q;
				cur_i_q  <= inh_rd_q;
				v_q      <= pot_rd_q;
				c_q      <= 34'($signed(exc_rd_q)) - 34'($signed(inh_rd_q))
					+ 34'($signed(bias_rd_q));
				w_spk_q  <= 1'b0;
				w_v_q    <= in_range ? pot_rd_q : 32'd0;
				w_refr_q <= (func_q == lnr_pkg::FUNC_UPD) && sel_ok && (rc_rd_q != 16'd0);
			end
			ST_MULC: begin
				pneg_q <= c_q[33] ^ resist_q[31];
			end
			ST_INP: begin
				inp_q <= pneg_q ? -INP_W'(p_mag) : INP_W'(p_mag);
			end
			ST_X: begin
				x_q <= x_sat;
			end
			ST_MHI: begin
				xneg_q <= x_q[XQ_W-1];
			end
			ST_MLO: begin
				hiprod_q <= HP_W'(prod);
			end
			ST_DV: begin
				dv_q <= xneg_q ? -DV_W'(hiprod_q + lo_ce) : DV_W'(hiprod_q + lo_fl);
			end
			ST_VUPD: begin
				w_v_q   <= v_new;
				w_spk_q <= fire;
			end
			ST_DECI: begin
				ne_q <= decay_next(cur_e_q, prod);
			end
			ST_WRE: begin
				ni_q <= decay_next(cur_i_q, prod);
			end
			default: ;
		endcase
		if (load_out) begin
			o_spk_q  <= w_spk_q;
			o_refr_q <= w_refr_q;
			o_v_q    <= w_v_q;
			o_idx_q  <= is_syn ? tgt[7:0] : sel_q;
		end
	end

	assign cmd.ready         = state_q == ST_IDLE;
	assign res.valid         = out_valid_q;
	assign res.spiked        = o_spk_q;
	assign res.neuron_out    = o_idx_q;
	assign res.membrane_v    = o_v_q;
	assign res.in_refractory = o_refr_q;

	`include "lif_neuron_with_psp_ring_assert.svh"

	`LNR_ASSERT_NEXT(a_one_item, accept, !cmd.ready)
	`LNR_ASSERT_SAME(a_load_at_fin, $rose(res.valid), $past(state_q) == ST_FIN)
	`LNR_ASSERT_SAME(a_refr_no_spike, res.valid && res.in_refractory, !res.spiked)

endmodule

`default_nettype wire

// File: sv/lnr_mul.sv
// ---------------------------------------------------------------------------
// lnr_mul
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module lnr_mul (
	input  wire logic                         clk,
	input  wire lnr_pkg::mul_req_t            req,
	output logic [lnr_pkg::MUL_P_W-1:0]       prod
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod <= lnr_pkg::MUL_P_W'(req.a) * lnr_pkg::MUL_P_W'(req.b);
		end
	end

endmodule

`default_nettype wire

// File: dv/lif_neuron_with_psp_ring_tb.sv
// ---------------------------------------------------------------------------
// lif_neuron_with_psp_ring_tb
// Self-checking testbench for the neuron array with delay rings. A directed
// table is followed by random phases of synapse, update and bias items under
// several register settings, checked against a fixed-point neuron predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module lif_neuron_with_psp_ring_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 235;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic [1:0]  func;
		logic [31:0] tick;
		logic [31:0] word;
		logic        last;
		logic [7:0]  sel;
		logic [31:0] bias;
	} cmd_t;

	typedef struct {
		logic        spk;
		logic [7:0]  nrn;
		logic [31:0] v;
		logic        refr;
	} nrn_res_t;

	typedef struct {
		cmd_t     c;
		bit       chk;
		nrn_res_t r;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lnr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lnr_pkg::CFG_DATA_W-1:0] cfg_data;

	lnr_cmd_if cmd_ch();
	lnr_res_if res_ch();

	lif_neuron_with_psp_ring dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd_ch), .res(res_ch)
	);

	logic [31:0] m_rest, m_reset, m_thresh, m_resist;
	logic [16:0] m_mdecay, m_edecay, m_idecay;
	logic [15:0] m_refr;
	logic [31:0] pot_mem [lnr_pkg::NEURONS];
	logic [15:0] refr_cnt [lnr_pkg::NEURONS];
	logic [31:0] bias_mem [lnr_pkg::NEURONS];
	logic [31:0] exc_ring [lnr_pkg::RING_DEPTH];
	logic [31:0] inh_ring [lnr_pkg::RING_DEPTH];

	nrn_res_t pending_q [$];
	int errs = 0;
	int cyc = 0;
	int n_items = 0;
	int n_res = 0;
	int n_spk = 0;
	int n_refr = 0;
	bit idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [127:0] clamp(logic signed [127:0] a, int lg);
		logic signed [127:0] lim;
		lim = 128'sd1 <<< lg;
		if (a > lim) return lim;
		if (a < -lim) return -lim;
		return a;
	endfunction

	function automatic logic [31:0] decay_cur(logic signed [127:0] cur, logic [16:0] d);
		logic signed [127:0] nxt;
		nxt = cur - ((cur * $signed({1'b0, d})) >>> lnr_pkg::SCALE_SHIFT);
		return nxt[31:0];
	endfunction

	function automatic nrn_res_t lif_predict(cmd_t c);
		nrn_res_t r;
		logic [10:0] tgt;
		logic [31:0] w, arr, nt;
		int at, now, nxt;
		logic signed [127:0] e, i, v, cur, inp, x;
		bit refr, fired;
		r = '{1'b0, c.sel, 32'd0, 1'b0};
		case (c.func)
			lnr_pkg::FUNC_SYN: begin
				tgt = c.word[26:16];
				r.nrn = tgt[7:0];
				if (tgt < lnr_pkg::NEURONS) begin
					w = (c.word & lnr_pkg::WEIGHT_MASK) << lnr_pkg::WEIGHT_SHIFT;
					arr = c.tick + 32'd1 + {28'd0, c.word[31:28]};
					at = tgt * lnr_pkg::RING_SLOTS + arr % lnr_pkg::RING_SLOTS;
					if (c.word[2:0] == lnr_pkg::SYN_EXCITE) exc_ring[at] += w;
					else if (c.word[2:0] == lnr_pkg::SYN_INHIBIT) inh_ring[at] += w;
					r.v = pot_mem[tgt];
				end
			end
			lnr_pkg::FUNC_BIAS: begin
				bias_mem[c.sel] = c.bias;
				r.v = pot_mem[c.sel];
			end
			lnr_pkg::FUNC_UPD: begin
				nt = c.tick + 32'd1;
				now = c.sel * lnr_pkg::RING_SLOTS + c.tick % lnr_pkg::RING_SLOTS;
				nxt = c.sel * lnr_pkg::RING_SLOTS + nt % lnr_pkg::RING_SLOTS;
				e = $signed(exc_ring[now]);
				i = $signed(inh_ring[now]);
				v = $signed(pot_mem[c.sel]);
				refr = refr_cnt[c.sel] != 0;
				fired = 1'b0;
				exc_ring[now] = '0;
				inh_ring[now] = '0;
				if (!refr) begin
					cur = e - i + $signed(bias_mem[c.sel]);
					inp = clamp((cur * $signed(m_resist)) >>> lnr_pkg::SCALE_SHIFT, 62);
					x = clamp($signed(m_rest) - v + inp, lnr_pkg::SCALE_SHIFT + 32);
					v = clamp(v + ((x * $signed({1'b0, m_mdecay})) >>> lnr_pkg::SCALE_SHIFT),
						31);
					if (v > 128'sd2147483647) v = 128'sd2147483647;
					if (v >= $signed(m_thresh)) begin
						fired = 1'b1;
						v = $signed(m_reset);
						refr_cnt[c.sel] = m_refr;
					end
					pot_mem[c.sel] = v[31:0];
				end else begin
					refr_cnt[c.sel] = refr_cnt[c.sel] - 16'd1;
				end
				exc_ring[nxt] += decay_cur(e, m_edecay);
				inh_ring[nxt] += decay_cur(i, m_idecay);
				r.spk = fired;
				r.v = pot_mem[c.sel];
				r.refr = refr;
			end
			default: r.v = pot_mem[c.sel];
		endcase
		return r;
	endfunction

	task automatic send_item(cmd_t c, bit chk, nrn_res_t typed);
		int gap;
		nrn_res_t r;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= c.func;
		cmd_ch.tick <= c.tick;
		cmd_ch.syn_word <= c.word;
		cmd_ch.row_last <= c.last;
		cmd_ch.neuron_sel <= c.sel;
		cmd_ch.bias_value <= c.bias;
		do @(posedge clk); while (!cmd_ch.ready);
		r = lif_predict(c);
		pending_q.push_back(chk ? typed : r);
		n_items++;
	endtask

	task automatic write_reg(logic [lnr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			lnr_pkg::REG_REST:   m_rest = val;
			lnr_pkg::REG_RESET:  m_reset = val;
			lnr_pkg::REG_THRESH: m_thresh = val;
			lnr_pkg::REG_MDECAY: m_mdecay = val[16:0];
			lnr_pkg::REG_RESIST: m_resist = val;
			lnr_pkg::REG_EDECAY: m_edecay = val[16:0];
			lnr_pkg::REG_IDECAY: m_idecay = val[16:0];
			default:             m_refr = val[15:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		cmd_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_profile(int p);
		case (p % 4)
			0: begin
				write_reg(lnr_pkg::REG_REST, $urandom_range(0, 32'h0010_0000));
				write_reg(lnr_pkg::REG_RESET, -$signed($urandom_range(0, 32'h0010_0000)));
				write_reg(lnr_pkg::REG_THRESH, $urandom_range(32'h0010_0000, 32'h0100_0000));
				write_reg(lnr_pkg::REG_MDECAY, $urandom_range(32'h1000, 65536));
				write_reg(lnr_pkg::REG_RESIST, $urandom_range(32'h4000, 32'h20000));
				write_reg(lnr_pkg::REG_EDECAY, $urandom_range(0, 65536));
				write_reg(lnr_pkg::REG_IDECAY, $urandom_range(0, 65536));
				write_reg(lnr_pkg::REG_REFR, $urandom_range(0, 4));
			end
			1: begin
				write_reg(lnr_pkg::REG_REST, 32'h7fff_ffff);
				write_reg(lnr_pkg::REG_RESET, 32'h7fff_ffff);
				write_reg(lnr_pkg::REG_THRESH, 32'h7fff_ffff);
				write_reg(lnr_pkg::REG_MDECAY, 32'd65536);
				write_reg(lnr_pkg::REG_RESIST, 32'h7fff_ffff);
				write_reg(lnr_pkg::REG_EDECAY, 32'd65536);
				write_reg(lnr_pkg::REG_IDECAY, 32'd65536);
				write_reg(lnr_pkg::REG_REFR, 32'd65535);
			end
			2: begin
				write_reg(lnr_pkg::REG_REST, 32'h8000_0000);
				write_reg(lnr_pkg::REG_RESET, 32'h8000_0000);
				write_reg(lnr_pkg::REG_THRESH, 32'h8000_0000);
				write_reg(lnr_pkg::REG_MDECAY, 32'd0);
				write_reg(lnr_pkg::REG_RESIST, 32'h8000_0000);
				write_reg(lnr_pkg::REG_EDECAY, 32'd0);
				write_reg(lnr_pkg::REG_IDECAY, 32'd0);
				write_reg(lnr_pkg::REG_REFR, 32'd0);
			end
			default: begin
				write_reg(lnr_pkg::REG_REST, $urandom);
				write_reg(lnr_pkg::REG_RESET, $urandom);
				write_reg(lnr_pkg::REG_THRESH, $urandom);
				write_reg(lnr_pkg::REG_MDECAY, $urandom_range(0, 65536));
				write_reg(lnr_pkg::REG_RESIST, $urandom);
				write_reg(lnr_pkg::REG_EDECAY, $urandom_range(0, 65536));
				write_reg(lnr_pkg::REG_IDECAY, $urandom_range(0, 65536));
				write_reg(lnr_pkg::REG_REFR, $urandom_range(0, 3) == 0
					? $urandom_range(0, 65535) : $urandom_range(0, 6));
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int count);
		cmd_t c;
		logic [31:0] cur_tick;
		logic [7:0] base;
		int roll;
		cur_tick = ($urandom_range(0, 3) == 0) ? 32'hffff_ffe0 + $urandom_range(0, 31) : $urandom;
		base = 8'($urandom_range(0, 248));
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			c.tick = cur_tick;
			c.last = 1'($urandom_range(0, 1));
			c.sel = base + 8'($urandom_range(0, 7));
			c.bias = $urandom;
			c.word = $urandom;
			if (roll < 40) begin
				c.func = lnr_pkg::FUNC_SYN;
				if ($urandom_range(0, 9) != 0) c.word[2:0] = 3'($urandom_range(0, 1));
				if ($urandom_range(0, 9) != 0) c.word[26:16] = {3'd0, c.sel};
			end else if (roll < 85) begin
				c.func = lnr_pkg::FUNC_UPD;
				if ($urandom_range(0, 3) == 0) cur_tick++;
			end else if (roll < 95) begin
				c.func = lnr_pkg::FUNC_BIAS;
				if ($urandom_range(0, 4) != 0)
					c.bias = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			end else begin
				c.func = 2'($urandom_range(0, 3));
				c.tick = $urandom;
				c.sel = 8'($urandom);
			end
			send_item(c, 1'b0, '{1'b0, 8'd0, 32'd0, 1'b0});
		end
	endtask

	dir_row_t dir_tab [] = '{
		'{'{lnr_pkg::FUNC_UPD, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'd0, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_SYN, 32'd5, 32'hf7ff_fff8, 1'b1, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'hff, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_SYN, 32'd5, 32'h0003_ffff, 1'b0, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'd3, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_SYN, 32'hffff_fff0, 32'hf001_fff8, 1'b0, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'd1, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_SYN, 32'hffff_fffe, 32'h0001_fff9, 1'b1, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'd1, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_SYN, 32'hffff_ffff, 32'h00ff_0008, 1'b0, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'hff, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_SYN, 32'h0, 32'h0100_0000, 1'b0, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'd0, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_BIAS, 32'd0, 32'd0, 1'b0, 8'd255, 32'h7fff_ffff}, 1'b1,
			'{1'b0, 8'd255, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_BIAS, 32'd0, 32'd0, 1'b1, 8'd0, 32'h8000_0000}, 1'b1,
			'{1'b0, 8'd0, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_UPD, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 8'd255, 32'd0}, 1'b1,
			'{1'b0, 8'd255, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_UPD, 32'hffff_ffff, 32'd0, 1'b0, 8'd1, 32'd0}, 1'b1,
			'{1'b0, 8'd1, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_UPD, 32'd0, 32'd0, 1'b0, 8'd1, 32'd0}, 1'b1,
			'{1'b0, 8'd1, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_UPD, 32'd1, 32'd0, 1'b0, 8'd0, 32'd0}, 1'b1,
			'{1'b0, 8'd0, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_UPD, 32'd15, 32'd0, 1'b0, 8'd1, 32'd0}, 1'b0,
			'{1'b0, 8'd0, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_BIAS, 32'd0, 32'd0, 1'b0, 8'd7, 32'h0001_0000}, 1'b0,
			'{1'b0, 8'd0, 32'd0, 1'b0}},
		'{'{lnr_pkg::FUNC_UPD, 32'd2, 32'd0, 1'b0, 8'd7, 32'd0}, 1'b0,
			'{1'b0, 8'd0, 32'd0, 1'b0}}
	};

	initial begin
		int hold_done;
		nrn_res_t e;
		int gap;
		hold_done = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = idle_on ? $urandom_range(0, 11) : 0;
			if (n_res == HOLD_AT && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done = 1;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			n_res++;
			if (res_ch.spiked) n_spk++;
			if (res_ch.in_refractory) n_refr++;
			if (pending_q.size() == 0) begin
				$error("result with nothing expected, neuron %0d", res_ch.neuron_out);
				errs++;
			end else begin
				e = pending_q.pop_front();
				if (res_ch.spiked !== e.spk) begin
					$error("spiked: expected %0d, got %0d", e.spk, res_ch.spiked);
					errs++;
				end
				if (res_ch.neuron_out !== e.nrn) begin
					$error("neuron_out: expected %0d, got %0d", e.nrn, res_ch.neuron_out);
					errs++;
				end
				if (res_ch.membrane_v !== e.v) begin
					$error("membrane_v: expected %0d, got %0d", $signed(e.v),
						res_ch.membrane_v);
					errs++;
				end
				if (res_ch.in_refractory !== e.refr) begin
					$error("in_refractory: expected %0d, got %0d", e.refr,
						res_ch.in_refractory);
					errs++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= lnr_pkg::FUNC_SYN;
		cmd_ch.tick <= '0;
		cmd_ch.syn_word <= '0;
		cmd_ch.row_last <= 1'b0;
		cmd_ch.neuron_sel <= '0;
		cmd_ch.bias_value <= '0;
		m_rest = '0;
		m_reset = '0;
		m_thresh = 32'h7fff_ffff;
		m_mdecay = '0;
		m_resist = '0;
		m_edecay = '0;
		m_idecay = '0;
		m_refr = '0;
		for (int n = 0; n < lnr_pkg::NEURONS; n++) begin
			pot_mem[n] = '0;
			refr_cnt[n] = '0;
			bias_mem[n] = '0;
		end
		for (int s = 0; s < lnr_pkg::RING_DEPTH; s++) begin
			exc_ring[s] = '0;
			inh_ring[s] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) send_item(dir_tab[k].c, dir_tab[k].chk, dir_tab[k].r);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_profile(p);
			idle_on = (p % 3) != 2;
			random_phase(PHASE_ITEMS);
			drain();
		end

		$display("Items sent: %0d, results checked: %0d.", n_items, n_res);
		$display("Spikes seen: %0d, refractory updates seen: %0d.", n_spk, n_refr);
		if (errs == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
